>>> hw/rtl/stt_pkg.sv
// Shared types, constants and character helpers for the source text tokenizer.
package stt_pkg;

  localparam int POSITION_BITS = 32;
  localparam int LENGTH_BITS   = 16;
  localparam int MAX_TOKENS    = 3;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_TDATA_BITS = 88;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [LENGTH_BITS-1:0]   len_t;

  localparam len_t LEN_MAX = '1;

  localparam logic [3:0] KIND_KEYWORD = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_INT     = 4'd2;
  localparam logic [3:0] KIND_COLON   = 4'd3;
  localparam logic [3:0] KIND_SEMI    = 4'd4;
  localparam logic [3:0] KIND_LPAREN  = 4'd5;
  localparam logic [3:0] KIND_RPAREN  = 4'd6;
  localparam logic [3:0] KIND_LBRACE  = 4'd7;
  localparam logic [3:0] KIND_RBRACE  = 4'd8;
  localparam logic [3:0] KIND_ERROR   = 4'd9;
  localparam logic [3:0] KIND_END     = 4'd10;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHAR     = 2'd1;
  localparam logic [1:0] ERR_COMMENT  = 2'd2;
  localparam logic [1:0] ERR_RANGE    = 2'd3;

  localparam logic KW_RETURN = 1'b0;
  localparam logic KW_I32    = 1'b1;
  localparam int   RETURN_LEN = 6;
  localparam int   I32_LEN    = 3;

  localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

  // One result item; kind sits in the low bits so it maps straight onto tdata.
  typedef struct packed {
    logic [1:0]  err;
    logic [15:0] length;
    logic [31:0] start;
    logic [30:0] lit_val;
    logic        kw;
    logic [3:0]  kind;
  } tok_t;

  localparam int TOK_BITS     = $bits(tok_t);
  localparam int OUT_PAD_BITS = OUT_TDATA_BITS - TOK_BITS;

  // All tokens caused by one input byte.
  typedef struct packed {
    logic [1:0]                 cnt;
    tok_t [MAX_TOKENS-1:0]      toks;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == ":") || (c == ";") || (c == "(") || (c == ")") ||
           (c == "{") || (c == "}");
  endfunction

  function automatic logic [3:0] punct_kind(input logic [7:0] c);
    logic [3:0] k;
    case (c)
      ":":     k = KIND_COLON;
      ";":     k = KIND_SEMI;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // True when character c matches keyword kw at position idx.
  function automatic logic kw_char_ok(input logic kw, input len_t idx,
                                      input logic [7:0] c);
    logic [7:0] ch;
    logic       in_range;
    ch = 8'h00;
    if (kw == KW_RETURN) begin
      in_range = (idx < len_t'(RETURN_LEN));
      case (idx[2:0])
        3'd0:    ch = "r";
        3'd1:    ch = "e";
        3'd2:    ch = "t";
        3'd3:    ch = "u";
        3'd4:    ch = "r";
        3'd5:    ch = "n";
        default: ch = 8'h00;
      endcase
    end else begin
      in_range = (idx < len_t'(I32_LEN));
      case (idx[2:0])
        3'd0:    ch = "i";
        3'd1:    ch = "3";
        3'd2:    ch = "2";
        default: ch = 8'h00;
      endcase
    end
    return in_range && (ch == c);
  endfunction

  function automatic logic [31:0] to_start(input pos_t p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

  function automatic logic [15:0] to_len(input len_t l);
    logic [31:0] w;
    w = 32'(l);
    return w[15:0];
  endfunction

  function automatic tok_t make_tok(input logic [3:0] kind, input logic kw,
                                    input logic [30:0] val, input pos_t start,
                                    input len_t len, input logic [1:0] err);
    tok_t t;
    t.kind      = kind;
    t.kw        = kw;
    t.lit_val   = val;
    t.start     = to_start(start);
    t.length    = to_len(len);
    t.err       = err;
    return t;
  endfunction

endpackage

>>> hw/rtl/stt_front.sv
// Front end: scans one byte per transaction and builds the bundle of tokens it causes.
module stt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          char_byte,
  input  logic                end_of_stream,
  output logic                push,
  output stt_pkg::bundle_t    bundle
);

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_WORD     = 3'd1;
  localparam logic [2:0] M_NUM      = 3'd2;
  localparam logic [2:0] M_SLASH    = 3'd3;
  localparam logic [2:0] M_CMT      = 3'd4;
  localparam logic [2:0] M_CMT_STAR = 3'd5;
  localparam logic [2:0] M_DISCARD  = 3'd6;

  logic [2:0]    mode_r, mode_nxt;
  stt_pkg::pos_t pos_r, pos_nxt;
  stt_pkg::pos_t start_r, start_nxt;
  stt_pkg::len_t run_r, run_nxt;
  logic [30:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    flags_r, flags_nxt;

  stt_pkg::tok_t [stt_pkg::MAX_TOKENS-1:0] toks;
  logic [1:0]    n;

  function automatic stt_pkg::tok_t word_tok(input logic [1:0] flags,
                                             input stt_pkg::len_t run,
                                             input stt_pkg::pos_t start);
    stt_pkg::tok_t t;
    if (flags[0] && (run == stt_pkg::len_t'(stt_pkg::RETURN_LEN))) begin
      t = stt_pkg::make_tok(stt_pkg::KIND_KEYWORD, stt_pkg::KW_RETURN, '0, start, run,
                            stt_pkg::ERR_NONE);
    end else if (flags[1] && (run == stt_pkg::len_t'(stt_pkg::I32_LEN))) begin
      t = stt_pkg::make_tok(stt_pkg::KIND_KEYWORD, stt_pkg::KW_I32, '0, start, run,
                            stt_pkg::ERR_NONE);
    end else begin
      t = stt_pkg::make_tok(stt_pkg::KIND_IDENT, 1'b0, '0, start, run, stt_pkg::ERR_NONE);
    end
    return t;
  endfunction

  function automatic stt_pkg::tok_t num_tok(input logic ovf, input logic [30:0] acc,
                                            input stt_pkg::pos_t start,
                                            input stt_pkg::len_t run);
    stt_pkg::tok_t t;
    if (ovf) begin
      t = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, '0, start, run, stt_pkg::ERR_RANGE);
    end else begin
      t = stt_pkg::make_tok(stt_pkg::KIND_INT, 1'b0, acc, start, run, stt_pkg::ERR_NONE);
    end
    return t;
  endfunction

  always_comb begin
    logic        do_idle;
    logic [34:0] v;
    logic [7:0]  c;
    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    flags_nxt = flags_r;
    toks      = '0;
    n         = 2'd0;
    do_idle   = 1'b0;
    v         = '0;
    c         = char_byte;

    case (mode_r)
      M_WORD: begin
        if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
          if (!stt_pkg::kw_char_ok(stt_pkg::KW_RETURN, run_r, c)) flags_nxt[0] = 1'b0;
          if (!stt_pkg::kw_char_ok(stt_pkg::KW_I32, run_r, c)) flags_nxt[1] = 1'b0;
          if (run_r != stt_pkg::LEN_MAX) run_nxt = run_r + stt_pkg::len_t'(1);
        end else begin
          toks[n] = word_tok(flags_r, run_r, start_r);
          n = n + 2'd1;
          mode_nxt = M_IDLE;
          do_idle = 1'b1;
        end
      end
      M_NUM: begin
        if (stt_pkg::is_digit(c)) begin
          if (run_r != stt_pkg::LEN_MAX) run_nxt = run_r + stt_pkg::len_t'(1);
          if (!ovf_r) begin
            // acc * 10 + digit as shift-add
            v = (35'(acc_r) << 3) + (35'(acc_r) << 1) + 35'(c - "0");
            if (v > 35'(stt_pkg::INT_MAX31)) begin
              ovf_nxt = 1'b1;
              acc_nxt = stt_pkg::INT_MAX31;
            end else begin
              acc_nxt = v[30:0];
            end
          end
        end else begin
          toks[n] = num_tok(ovf_r, acc_r, start_r, run_r);
          n = n + 2'd1;
          if (ovf_r) begin
            mode_nxt = M_DISCARD;  // delimiter is dropped
          end else begin
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
      end
      M_SLASH: begin
        if (c == "*") begin
          mode_nxt = M_CMT;
        end else begin
          toks[n] = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, '0, start_r,
                                      stt_pkg::len_t'(1), stt_pkg::ERR_CHAR);
          n = n + 2'd1;
          mode_nxt = M_DISCARD;
        end
      end
      M_CMT: begin
        if (c == "*") mode_nxt = M_CMT_STAR;
      end
      M_CMT_STAR: begin
        if (c == "/") begin
          mode_nxt = M_IDLE;
        end else if (c != "*") begin
          mode_nxt = M_CMT;
        end
      end
      M_DISCARD: begin
        mode_nxt = M_DISCARD;
      end
      default: begin
        mode_nxt = M_IDLE;
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      if (stt_pkg::is_space(c)) begin
        mode_nxt = M_IDLE;
      end else if (stt_pkg::is_letter(c)) begin
        mode_nxt  = M_WORD;
        start_nxt = pos_r;
        run_nxt   = stt_pkg::len_t'(1);
        flags_nxt = {stt_pkg::kw_char_ok(stt_pkg::KW_I32, '0, c),
                     stt_pkg::kw_char_ok(stt_pkg::KW_RETURN, '0, c)};
      end else if (stt_pkg::is_digit(c)) begin
        mode_nxt  = M_NUM;
        start_nxt = pos_r;
        run_nxt   = stt_pkg::len_t'(1);
        acc_nxt   = 31'(c - "0");
        ovf_nxt   = 1'b0;
      end else if (c == "/") begin
        mode_nxt  = M_SLASH;
        start_nxt = pos_r;
      end else if (stt_pkg::is_punct(c)) begin
        toks[n] = stt_pkg::make_tok(stt_pkg::punct_kind(c), 1'b0, '0, pos_r,
                                    stt_pkg::len_t'(1), stt_pkg::ERR_NONE);
        n = n + 2'd1;
      end else begin
        toks[n] = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, '0, pos_r,
                                    stt_pkg::len_t'(1), stt_pkg::ERR_CHAR);
        n = n + 2'd1;
        mode_nxt = M_DISCARD;
      end
    end

    if (end_of_stream) begin
      case (mode_nxt)
        M_WORD: begin
          toks[n] = word_tok(flags_nxt, run_nxt, start_nxt);
          n = n + 2'd1;
        end
        M_NUM: begin
          toks[n] = num_tok(ovf_nxt, acc_nxt, start_nxt, run_nxt);
          n = n + 2'd1;
        end
        M_SLASH: begin
          toks[n] = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, '0, start_nxt,
                                      stt_pkg::len_t'(1), stt_pkg::ERR_CHAR);
          n = n + 2'd1;
        end
        M_CMT, M_CMT_STAR: begin
          toks[n] = stt_pkg::make_tok(stt_pkg::KIND_ERROR, 1'b0, '0, start_nxt,
                                      '0, stt_pkg::ERR_COMMENT);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      toks[n] = stt_pkg::make_tok(stt_pkg::KIND_END, 1'b0, '0,
                                  pos_r + stt_pkg::pos_t'(1), '0, stt_pkg::ERR_NONE);
      n = n + 2'd1;
      // next byte opens a fresh stream
      mode_nxt  = M_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      run_nxt   = '0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
      flags_nxt = 2'b11;
    end else begin
      pos_nxt = pos_r + stt_pkg::pos_t'(1);
    end
  end

  assign push        = accept && (n != 2'd0);
  assign bundle.cnt  = n;
  assign bundle.toks = toks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      run_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      flags_r <= 2'b11;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      run_r   <= run_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

>>> hw/rtl/stt_queue.sv
// Small FIFO of token bundles between the scanner and the output serializer.
module stt_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  stt_pkg::bundle_t push_data,
  input  logic             pop,
  output stt_pkg::bundle_t head,
  output logic             not_empty,
  output logic             full
);

  stt_pkg::bundle_t mem_r [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [stt_pkg::QCNT_BITS-1:0] cnt_r, cnt_nxt;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == stt_pkg::QCNT_BITS'(stt_pkg::QUEUE_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + stt_pkg::QCNT_BITS'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - stt_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + stt_pkg::QPTR_BITS'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + stt_pkg::QPTR_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> hw/rtl/stt_back.sv
// Back end: head bundle -> output register, one token per cycle unless stalled.
module stt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  stt_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output stt_pkg::tok_t    out_tok,
  output logic             out_last
);

  logic [1:0]    idx_r;
  logic          valid_r;
  stt_pkg::tok_t tok_r;
  logic          last_r;
  logic          load;
  logic          is_last;

  assign load    = head_valid && (!valid_r || out_ready);
  assign is_last = (idx_r == (head.cnt - 2'd1));
  assign pop     = load && is_last;

  assign out_valid = valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= is_last ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tok_r  <= head.toks[idx_r];
      last_r <= is_last;
    end
  end

endmodule

>>> hw/rtl/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: scanner, bundle queue and output serializer.
// Takes one source byte per transaction (in_tlast on the final byte) and returns tokens,
// out_tlast marking the last token caused by a byte. A byte is accepted in every cycle
// that the two-entry bundle queue has room; tokens leave one per cycle from the output
// register while out_tready is high, and sustained throughput is one byte per cycle while
// bytes average at most one token each and out_tready stays high. out_tvalid for the
// first token of a byte rises once its bundle has passed through the queue into the
// output register. No clearing pass follows reset.
module source_text_tokenizer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  input  logic        in_tlast,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] token_kind, [4] keyword_id, [35:5] literal value, [67:36] token_start,
  // [83:68] token_length, [85:84] error_code, [87:86] zero
  output logic [stt_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  output logic        out_tlast   // last_of_run
);

  logic             accept;
  logic             push;
  stt_pkg::bundle_t push_bundle;
  stt_pkg::bundle_t head;
  logic             head_valid;
  logic             q_full;
  logic             pop;
  stt_pkg::tok_t    tok;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  stt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .char_byte     (in_tdata),
    .end_of_stream (in_tlast),
    .push          (push),
    .bundle        (push_bundle)
  );

  stt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_bundle),
    .pop       (pop),
    .head      (head),
    .not_empty (head_valid),
    .full      (q_full)
  );

  stt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_tok    (tok),
    .out_last   (out_tlast)
  );

  assign out_tdata = {{stt_pkg::OUT_PAD_BITS{1'b0}}, tok};

endmodule
